[rtl/uvs_pkg.sv]
// shared types and constants of the uv sphere index generator
// walk state, triangle word and register codes; depends on nothing

package uvs_pkg;

	localparam int IDX_W      = 17;
	localparam int CFG_W      = 9;
	localparam int RING_W     = 8;
	localparam int CFG_ADDR_W = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_LAT_SLICES  = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_LONG_SLICES = CFG_ADDR_W'(1);

	localparam logic [CFG_W-1:0] LAT_RESET  = CFG_W'(16);
	localparam logic [CFG_W-1:0] LONG_RESET = CFG_W'(16);
	localparam logic [CFG_W-1:0] LAT_MIN    = CFG_W'(3);
	localparam logic [CFG_W-1:0] LONG_MIN   = CFG_W'(1);

	typedef enum logic [1:0] {
		SEC_TOP  = 2'd0,
		SEC_BAND = 2'd1,
		SEC_BOT  = 2'd2
	} section_t;

	typedef struct packed {
		section_t            section;
		logic [RING_W-1:0]   ring_row;
		logic [RING_W-1:0]   ring_column;
		logic                second_half;
		logic [IDX_W-1:0]    corner_index;
	} walk_t;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_a;
		logic [IDX_W-1:0] vertex_b;
		logic [IDX_W-1:0] vertex_c;
		section_t         section;
		logic             last_triangle;
	} tri_t;

	localparam walk_t WALK_START = '{
		section:      SEC_TOP,
		ring_row:     '0,
		ring_column:  '0,
		second_half:  1'b0,
		corner_index: IDX_W'(1)
	};

endpackage

[rtl/uv_sphere_index_generator_core.sv]
// top level of the uv sphere index generator: registers, handshakes, result register
// uses uvs_pkg and the step logic in uvs_step

// Triangle index source for a latitude/longitude sphere.
// Configuration: write lat_slices at index 0 and long_slices at index 1 over the
// cfg channel (cfg_ready is always high). Values are saturated on use to
// 3..MAX_SLICES and 1..MAX_SLICES. Any accepted register write returns the walk
// to the first triangle; writes to other indices are ignored.
// Input: each accepted word (restart) yields exactly one triangle. restart = 1
// starts over at the first triangle of the top cap, 0 takes the next one.
// Output: vertex_a/b/c, section and last_triangle, held in one result register.
// After last_triangle the walk wraps to the first triangle by itself.
// out_valid rises in the cycle after an input word is accepted; throughput is
// one triangle per cycle while the receiver keeps out_ready high, set by the
// single walk-state update between registers. When the receiver stalls, the
// result stays put and in_ready drops until it is taken; a word is taken in
// the same cycle the pending result leaves. Reset sets both registers to 16,
// puts the walk at the first triangle and empties the result register.

module uv_sphere_index_generator_core import uvs_pkg::*; #(
	parameter int MAX_SLICES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      vertex_a,
	output logic [IDX_W-1:0]      vertex_b,
	output logic [IDX_W-1:0]      vertex_c,
	output logic [1:0]            section,
	output logic                  last_triangle
);

	localparam logic [CFG_W-1:0] SLICES_MAX = CFG_W'(MAX_SLICES);

	logic [CFG_W-1:0]   lat_q;
	logic [CFG_W-1:0]   long_q;
	walk_t              walk_q;
	logic               out_valid_q;
	tri_t               result_q;

	logic [CFG_W-1:0]   lat_eff;
	logic [CFG_W-1:0]   long_eff;
	logic [2*CFG_W-1:0] prod;
	logic [IDX_W-1:0]   pole_bot;
	logic [IDX_W-1:0]   last_ring;
	tri_t               tri_nxt;
	walk_t              walk_nxt;
	logic               in_acc;
	logic               cfg_acc;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	always_comb begin
		if (lat_q < LAT_MIN) begin
			lat_eff = LAT_MIN;
		end else if (lat_q > SLICES_MAX) begin
			lat_eff = SLICES_MAX;
		end else begin
			lat_eff = lat_q;
		end
		if (long_q < LONG_MIN) begin
			long_eff = LONG_MIN;
		end else if (long_q > SLICES_MAX) begin
			long_eff = SLICES_MAX;
		end else begin
			long_eff = long_q;
		end
		prod      = lat_eff * long_eff;
		pole_bot  = prod[IDX_W-1:0] + IDX_W'(1);
		// first vertex of the last ring
		last_ring = pole_bot - IDX_W'(lat_eff);
	end

	uvs_step u_step (
		.walk_i   (walk_q),
		.restart  (restart),
		.lat_eff  (lat_eff),
		.long_eff (long_eff),
		.pole_bot (pole_bot),
		.last_ring(last_ring),
		.tri_o    (tri_nxt),
		.walk_nxt (walk_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q       <= LAT_RESET;
			long_q      <= LONG_RESET;
			walk_q      <= WALK_START;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_acc && cfg_index == REG_LAT_SLICES) begin
				lat_q  <= cfg_data;
				walk_q <= WALK_START;
			end else if (cfg_acc && cfg_index == REG_LONG_SLICES) begin
				long_q <= cfg_data;
				walk_q <= WALK_START;
			end else if (in_acc) begin
				walk_q <= walk_nxt;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_q <= tri_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex_a      = result_q.vertex_a;
	assign vertex_b      = result_q.vertex_b;
	assign vertex_c      = result_q.vertex_c;
	assign section       = result_q.section;
	assign last_triangle = result_q.last_triangle;

	a_acc_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted word produced no result");

	a_restart_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && restart) |=> (section == SEC_TOP && vertex_a == '0 &&
			vertex_b == IDX_W'(1) && vertex_c == IDX_W'(2)))
		else $error("restart did not give the first triangle");

	a_last_in_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_triangle) |-> section == SEC_BOT)
		else $error("last triangle flagged outside the bottom cap");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && tri_nxt.last_triangle) |=>
			(walk_q.section == SEC_TOP && walk_q.corner_index == IDX_W'(1)))
		else $error("walk did not wrap after the last triangle");

	a_top_fan_pole: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && section == SEC_TOP) |-> vertex_a == '0)
		else $error("top cap triangle not anchored at the pole");

endmodule

[rtl/uvs_step.sv]
// one step of the sphere walk: the triangle for the current position and the next position
// uses uvs_pkg for the walk state and triangle word

module uvs_step import uvs_pkg::*; (
	input  walk_t            walk_i,
	input  logic             restart,
	input  logic [CFG_W-1:0] lat_eff,
	input  logic [CFG_W-1:0] long_eff,
	input  logic [IDX_W-1:0] pole_bot,
	input  logic [IDX_W-1:0] last_ring,
	output tri_t             tri_o,
	output walk_t            walk_nxt
);

	walk_t            cur;
	logic             ring_end;
	logic [IDX_W-1:0] lat_x;
	logic [IDX_W-1:0] tl;
	logic [IDX_W-1:0] bl;
	logic [IDX_W-1:0] tr;
	logic [IDX_W-1:0] br;
	logic             more_rows;

	always_comb begin
		if (restart || !(walk_i.section == SEC_TOP || walk_i.section == SEC_BAND ||
				walk_i.section == SEC_BOT)) begin
			cur = WALK_START;
		end else begin
			cur = walk_i;
		end
		ring_end  = {1'b0, cur.ring_column} >= (lat_eff - CFG_W'(1));
		lat_x     = IDX_W'(lat_eff);
		tl        = cur.corner_index;
		bl        = tl + lat_x;
		tr        = ring_end ? (tl - (lat_x - IDX_W'(1))) : (tl + IDX_W'(1));
		br        = tr + lat_x;
		more_rows = ({1'b0, cur.ring_row} + CFG_W'(2)) < long_eff;

		tri_o               = '0;
		tri_o.section       = cur.section;
		walk_nxt            = cur;

		case (cur.section)
			SEC_TOP: begin
				tri_o.vertex_a = '0;
				tri_o.vertex_b = tl;
				tri_o.vertex_c = ring_end ? IDX_W'(1) : tl + IDX_W'(1);
				if (!ring_end) begin
					walk_nxt.ring_column  = cur.ring_column + RING_W'(1);
					walk_nxt.corner_index = tl + IDX_W'(1);
				end else if (long_eff >= CFG_W'(2)) begin
					walk_nxt.section      = SEC_BAND;
					walk_nxt.ring_row     = '0;
					walk_nxt.ring_column  = '0;
					walk_nxt.second_half  = 1'b0;
					walk_nxt.corner_index = IDX_W'(1);
				end else begin
					// single ring: straight to the bottom fan
					walk_nxt.section      = SEC_BOT;
					walk_nxt.ring_column  = '0;
					walk_nxt.corner_index = last_ring;
				end
			end
			SEC_BAND: begin
				if (!cur.second_half) begin
					tri_o.vertex_a       = tl;
					tri_o.vertex_b       = bl;
					tri_o.vertex_c       = tr;
					walk_nxt.second_half = 1'b1;
				end else begin
					tri_o.vertex_a        = tr;
					tri_o.vertex_b        = bl;
					tri_o.vertex_c        = br;
					walk_nxt.second_half  = 1'b0;
					// stepping past the ring end lands on the next ring's first vertex
					walk_nxt.corner_index = tl + IDX_W'(1);
					if (!ring_end) begin
						walk_nxt.ring_column = cur.ring_column + RING_W'(1);
					end else begin
						walk_nxt.ring_column = '0;
						if (more_rows) begin
							walk_nxt.ring_row = cur.ring_row + RING_W'(1);
						end else begin
							walk_nxt.section      = SEC_BOT;
							walk_nxt.ring_row     = '0;
							walk_nxt.corner_index = last_ring;
						end
					end
				end
			end
			SEC_BOT: begin
				tri_o.vertex_a      = tl;
				tri_o.vertex_b      = pole_bot;
				tri_o.vertex_c      = ring_end ? last_ring : tl + IDX_W'(1);
				tri_o.last_triangle = ring_end;
				if (!ring_end) begin
					walk_nxt.ring_column  = cur.ring_column + RING_W'(1);
					walk_nxt.corner_index = tl + IDX_W'(1);
				end else begin
					walk_nxt = WALK_START;
				end
			end
			default: begin
				walk_nxt = WALK_START;
			end
		endcase
	end

endmodule
